>>> rtl/assert_macros.svh
// assertion helpers included by gaussian_sum_evaluator_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
	else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
	else $error("assertion failed");

`endif

>>> rtl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// shared constants and types of the gaussian sum evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gse_pkg;
	localparam int unsigned LOG2E_Q16       = 94548;
	localparam int unsigned INV_SQRT2PI_Q24 = 6693141;

	// register indexes
	localparam logic [2:0] REG_PEAK_COUNT = 3'd0;
	localparam logic [2:0] REG_NORM_MODE  = 3'd1;
	localparam logic [2:0] REG_OFFSET     = 3'd2;
	localparam logic [2:0] REG_PEAK0      = 3'd3;
	localparam logic [2:0] REG_PEAK1      = 3'd4;
	localparam logic [2:0] REG_PEAK2      = 3'd5;
	localparam logic [2:0] REG_PEAK3      = 3'd6;

	typedef struct packed {
		logic signed [23:0] model_value;
		logic               saturated;
		logic               zero_width_seen;
	} result_t;
endpackage

>>> rtl/gse_if.sv
// ----------------------------------------------------------------------------
// gse_stream_if / gse_cfg_if
// valid/ready channels for samples, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface gse_stream_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gse_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/gaussian_sum_evaluator_top.sv
// ----------------------------------------------------------------------------
// gaussian_sum_evaluator_top
// sum of gaussian peaks plus a baseline, one point at a time
// ----------------------------------------------------------------------------
// Each sample is worked through by the sequencer around one shared 32x32
// multiplier and a 47-step serial divider: one division for t per enabled
// peak, a second division for the norm in normalized mode, and no division
// for a zero-width peak. The finished result waits in an output register
// while the next sample is taken in; the last step stalls only while that
// register is full and not being read. Register writes are taken only while
// no sample is in flight. The exp table entry count must be a power of two.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gaussian_sum_evaluator_top import gse_pkg::*; #(
	parameter int MAX_PEAKS         = 4,
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input logic          clk,
	input logic          arst_n,
	gse_cfg_if.sink      cfg,
	gse_stream_if.sink   sample,
	gse_stream_if.source result
);
	localparam int IW = $clog2(EXP_TABLE_ENTRIES);

	// ceil(2^34 / k) for k = 1..12, exact floor division in the series
	localparam logic [34:0] RECIP_K [12] = '{
		35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
		35'd3435973837, 35'd2863311531, 35'd2454267027, 35'd2147483648,
		35'd1908874354, 35'd1717986919, 35'd1561806290, 35'd1431655766
	};

	typedef enum logic [3:0] {
		S_IDLE, S_PEAK, S_DIV, S_EXP0, S_EXP1, S_NORM, S_MUL0, S_MUL1, S_ACC, S_FIN0,
		S_FIN1
	} state_t;

	// exp table, built at elaboration from the integer series
	function automatic logic [15:0] exp_entry(input int unsigned idx);
		logic [63:0] y, term, sum, r;
		y = (64'(idx) * 64'd744261118) >> IW;
		term = 64'd1 << 30;
		sum = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = (((term * y) >> 30) * RECIP_K[4'(k - 1)]) >> 34;
			if (k[0]) sum = sum - term;
			else sum = sum + term;
		end
		r = (sum + 64'd8192) >> 14;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	logic [15:0] exp_rom [EXP_TABLE_ENTRIES];
	for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
		assign exp_rom[g] = exp_entry(g);
	end

	// configuration registers
	logic [2:0]         count_q;
	logic               norm_mode_q;
	logic [15:0]        offset_q;
	logic [47:0]        peak_q [4];

	// datapath registers
	state_t             state_q, ret_q;
	logic [2:0]         p_q, lim_q;
	logic signed [15:0] x_q, amp_q;
	logic [15:0]        w_q;
	logic [16:0]        dmag_q;
	logic [46:0]        num_q;       // dividend / quotient shift register
	logic [31:0]        den_q;
	logic [31:0]        rem_q;
	logic [5:0]         bit_q;
	logic [19:0]        t_q;
	logic [35:0]        z_q;
	logic [15:0]        e_q;
	logic [23:0]        norm_q;
	logic [31:0]        mul_q;
	logic signed [63:0] acc_q;
	logic               zero_q, out_valid_q;
	result_t            res_q;

	assign cfg.ready = (state_q == S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd1;
			norm_mode_q <= 1'b0;
			offset_q <= '0;
			for (int i = 0; i < 4; i++) peak_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PEAK_COUNT: count_q <= cfg.wdata[2:0];
				REG_NORM_MODE:  norm_mode_q <= cfg.wdata[0];
				REG_OFFSET:     offset_q <= cfg.wdata[15:0];
				default: if (cfg.index inside {[REG_PEAK0:REG_PEAK3]})
					peak_q[2'(cfg.index - REG_PEAK0)] <= cfg.wdata;
			endcase
		end
	end

	// p_q points one past the peak being worked on
	logic [47:0] pw;
	assign pw = peak_q[2'(p_q - 3'd1)];

	// magnitude of the amplitude, full range
	logic [15:0] amag;
	assign amag = amp_q[15] ? 16'(-amp_q) : 16'(amp_q);

	// shared multiplier
	logic [31:0] ma, mb;
	logic [63:0] mp;
	assign mp = ma * mb;
	always_comb begin
		ma = '0; mb = '0;
		case (state_q)
			S_PEAK: begin ma = 32'(pw[31:16]); mb = 32'(pw[31:16]); end
			S_DIV:  begin ma = 32'(dmag_q); mb = 32'(dmag_q); end
			S_EXP0: begin ma = 32'(t_q); mb = 32'(LOG2E_Q16); end
			S_MUL0: begin ma = 32'(amag); mb = 32'(e_q); end
			S_MUL1: begin ma = mul_q; mb = 32'(norm_q); end
			default: ;
		endcase
	end

	// one restoring division step
	logic [33:0] trial;
	assign trial = {1'b0, rem_q, num_q[46]} - {2'b0, den_q};

	logic [2:0] lim_d;
	assign lim_d = (count_q > 3'(MAX_PEAKS)) ? 3'(MAX_PEAKS) : count_q;

	logic signed [16:0] dd;
	assign dd = 17'(x_q) - 17'(signed'(pw[15:0]));

	logic [IW-1:0] idx;
	assign idx = IW'(z_q[15:0] >> (16 - IW));

	logic signed [63:0] biased;
	logic signed [31:0] yv;
	assign biased = acc_q + (64'(signed'(offset_q)) <<< 32) + 64'sh80000000;
	assign yv = 32'(biased >>> 32);

	// last step may finish once the output register is free or draining
	logic fin_go;
	assign fin_go = (state_q == S_FIN1) && (!out_valid_q || result.ready);

	assign sample.ready = (state_q == S_IDLE) && !cfg.valid;
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			out_valid_q <= 1'b0;
			p_q <= '0;
			lim_q <= '0;
			x_q <= '0;
			amp_q <= '0;
			w_q <= '0;
			dmag_q <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			t_q <= '0;
			z_q <= '0;
			e_q <= '0;
			norm_q <= '0;
			mul_q <= '0;
			acc_q <= '0;
			zero_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (sample.valid && sample.ready) begin
					x_q <= sample.data;
					p_q <= '0;
					lim_q <= lim_d;
					acc_q <= '0;
					zero_q <= 1'b0;
					state_q <= S_ACC;
					ret_q <= S_PEAK;
				end
				S_PEAK: begin
					amp_q <= signed'(pw[47:32]);
					w_q <= pw[31:16];
					dmag_q <= dd[16] ? 17'(-dd) : 17'(dd);
					den_q <= mp[31:0];
					state_q <= S_DIV;
					if (pw[31:16] == 16'd0) begin
						zero_q <= 1'b1;
						state_q <= S_ACC;
						ret_q <= S_PEAK;
					end
				end
				S_DIV: begin
					// first entry loads (d^2<<15)/(w^2)
					num_q <= {mp[31:0], 15'd0};
					rem_q <= '0;
					bit_q <= 6'd47;
					state_q <= S_EXP1;
					ret_q <= S_EXP0;
				end
				S_EXP1: begin
					// shared serial divider
					if (bit_q != 0) begin
						bit_q <= bit_q - 6'd1;
						if (!trial[33]) begin
							rem_q <= trial[31:0];
							num_q <= {num_q[45:0], 1'b1};
						end else begin
							rem_q <= {rem_q[30:0], num_q[46]};
							num_q <= {num_q[45:0], 1'b0};
						end
					end else if (ret_q == S_EXP0) begin
						t_q <= (num_q[46:20] != '0) ? 20'hFFFFF : num_q[19:0];
						state_q <= S_EXP0;
					end else begin
						norm_q <= num_q[23:0];
						state_q <= S_MUL0;
					end
				end
				S_EXP0: begin
					z_q <= mp[51:16];
					state_q <= S_NORM;
				end
				S_NORM: begin
					e_q <= (t_q == 20'hFFFFF || z_q[35:16] > 20'd15) ? 16'd0
						: exp_rom[idx] >> z_q[19:16];
					if (norm_mode_q) begin
						num_q <= 47'(INV_SQRT2PI_Q24 + 32'(w_q >> 1));
						den_q <= 32'(w_q);
						rem_q <= '0;
						bit_q <= 6'd47;
						ret_q <= S_NORM;
						state_q <= S_EXP1;
					end else begin
						norm_q <= 24'd65536;
						state_q <= S_MUL0;
					end
				end
				S_MUL0: begin
					mul_q <= mp[31:0];
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					acc_q <= amp_q[15] ? acc_q - 64'(mp) : acc_q + 64'(mp);
					state_q <= S_ACC;
					ret_q <= S_PEAK;
				end
				S_ACC: begin
					// hand over to S_FIN0, which advances to the next peak or finishes
					state_q <= S_FIN0;
				end
				S_FIN0: begin
					if (p_q < lim_q) begin
						state_q <= S_PEAK;
						p_q <= p_q + 3'd1;
					end else begin
						state_q <= S_FIN1;
					end
				end
				S_FIN1: if (fin_go) begin
					res_q.zero_width_seen <= zero_q;
					if (yv > 32'sd8388607) begin
						res_q.model_value <= 24'h7FFFFF; res_q.saturated <= 1'b1;
					end else if (yv < -32'sd8388608) begin
						res_q.model_value <= 24'h800000; res_q.saturated <= 1'b1;
					end else begin
						res_q.model_value <= yv[23:0]; res_q.saturated <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !sample.ready)
	`ASSERT_NEXT(a_fin_valid, clk, arst_n, state_q == S_FIN1, out_valid_q)
	`ASSERT_IMPL(a_peak_range, clk, arst_n, state_q == S_PEAK, p_q <= 3'(MAX_PEAKS))
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the gaussian sum evaluator: a queue-fed sample
// driver, a result monitor checked against an in-bench fixed-point predictor,
// register phases between idle points, random gaps and a long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import gse_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TABLE_SIZE     = 256;
	localparam int STALL_CYCLES   = 3000;

	logic clk;
	logic arst_n;

	gse_cfg_if           cfg_ch();
	gse_stream_if #(16)  sample_ch();
	gse_stream_if #(26)  result_ch();

	gaussian_sum_evaluator_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	// predictor copy of the registers
	logic [2:0]  m_count;
	logic        m_norm;
	logic [15:0] m_offset;
	logic [47:0] m_peak [4];
	logic [15:0] exp_lut [TABLE_SIZE];

	logic [15:0] sample_q [$];
	result_t     result_q [$];

	int   errors = 0;
	bit   stall_on = 1'b0;
	event stall_go;
	bit   tx_gap_ok;
	int   tx_gap;
	int   rx_gap;
	int   idle_cycles = 0;

	// 2^(-i/256) in Q0.16 by integer series
	function automatic logic [15:0] lut_entry(int unsigned idx);
		logic [63:0] y, term, sum, r;
		y = (64'(idx) * 64'd744261118) / TABLE_SIZE;
		term = 64'd1 << 30;
		sum = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * y) >> 30) / k;
			if (k & 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		r = (sum + 64'd8192) >> 14;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [63:0] gauss_term(logic [63:0] dmag, logic [63:0] w);
		logic [63:0] t, z, n, f, idx;
		t = ((dmag * dmag) << 15) / (w * w);
		if (t >= (64'd16 << 16))
			return 0;
		z = (t * 64'd94548) >> 16;
		n = z >> 16;
		f = z & 64'hFFFF;
		idx = (f * TABLE_SIZE) >> 16;
		if (idx >= TABLE_SIZE)
			idx = TABLE_SIZE - 1;
		return 64'(exp_lut[idx]) >> n;
	endfunction

	function automatic result_t evaluate_point(logic [15:0] xs);
		result_t r;
		int count;
		longint acc, y;
		logic signed [16:0] d;
		logic signed [15:0] amp, ctr;
		logic [63:0] w, dmag, nrm, mag;
		acc = 0;
		r = '0;
		count = (m_count > 4) ? 4 : m_count;
		for (int p = 0; p < count; p++) begin
			amp = m_peak[p][47:32];
			w = 64'(m_peak[p][31:16]);
			ctr = m_peak[p][15:0];
			d = 17'(signed'(xs)) - 17'(ctr);
			dmag = (d < 0) ? 64'(-32'(d)) : 64'(32'(d));
			if (w == 0) begin
				r.zero_width_seen = 1'b1;
				continue;
			end
			nrm = m_norm ? (64'd6693141 + w / 2) / w : 64'd65536;
			mag = 64'((amp < 0) ? -32'(amp) : 32'(amp)) * nrm * gauss_term(dmag, w);
			if (amp < 0)
				acc -= longint'(mag);
			else
				acc += longint'(mag);
		end
		acc += longint'(signed'(m_offset)) <<< 32;
		y = (acc + (longint'(1) <<< 31)) >>> 32;
		if (y > 8388607) begin
			y = 8388607;
			r.saturated = 1'b1;
		end else if (y < -8388608) begin
			y = -8388608;
			r.saturated = 1'b1;
		end
		r.model_value = y[23:0];
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// sample driver, head of the queue is the beat on offer
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.data  <= '0;
			tx_gap <= 0;
		end else begin
			g = tx_gap;
			if (sample_ch.valid && sample_ch.ready) begin
				result_q = {result_q, evaluate_point(sample_ch.data)};
				void'(sample_q.pop_front());
				g = pick_gap();
			end
			if (sample_ch.valid && !sample_ch.ready) begin
				// hold current beat
			end else if (g > 0) begin
				tx_gap <= g - 1;
				sample_ch.valid <= 1'b0;
			end else if (tx_gap_ok && sample_q.size() > 0) begin
				tx_gap <= 0;
				sample_ch.valid <= 1'b1;
				sample_ch.data  <= sample_q[0];
			end else begin
				tx_gap <= 0;
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = result_q.pop_front();
					if (got.model_value !== want.model_value ||
							got.saturated !== want.saturated ||
							got.zero_width_seen !== want.zero_width_seen) begin
						errors++;
						if (errors <= 10)
							$display("result: expected %h/%b/%b got %h/%b/%b",
								want.model_value, want.saturated, want.zero_width_seen,
								got.model_value, got.saturated, got.zero_width_seen);
					end
				end
			end
			if (stall_on) begin
				result_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	// long output stall counted here
	always begin
		@(stall_go);
		stall_on <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_on <= 1'b0;
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || (sample_q.size() == 0 &&
				result_q.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("gaussian_sum_evaluator_top: mismatch");
			$finish;
		end
	end

	task automatic queue_sample(input logic [15:0] v);
		sample_q = {sample_q, v};
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_PEAK_COUNT: m_count = val[2:0];
			REG_NORM_MODE:  m_norm = val[0];
			REG_OFFSET:     m_offset = val[15:0];
			default: if (idx >= REG_PEAK0 && idx <= REG_PEAK3)
				m_peak[2'(idx - REG_PEAK0)] = val;
		endcase
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || result_q.size() != 0 || sample_ch.valid)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_peak(bit narrow);
		logic [15:0] amp, w, c;
		amp = 16'($urandom());
		c = 16'($urandom());
		if ($urandom_range(0, 9) == 0)
			w = 16'd0;
		else if (narrow)
			w = 16'($urandom_range(1, 16'h0800));
		else
			w = 16'($urandom());
		return {amp, w, c};
	endfunction

	task automatic random_phase(int n, bit cluster);
		logic [15:0] ctr;
		write_reg(REG_PEAK_COUNT, 48'($urandom_range(0, 7)));
		write_reg(REG_NORM_MODE, 48'($urandom_range(0, 1)));
		write_reg(REG_OFFSET, 48'($urandom()));
		for (int p = 0; p < 4; p++)
			write_reg(3'(REG_PEAK0 + p), rand_peak(cluster));
		for (int i = 0; i < n; i++) begin
			ctr = m_peak[2'($urandom_range(0, 3))][15:0];
			// mostly near a center so the exponent is live
			if (cluster && $urandom_range(0, 3) != 0)
				queue_sample(ctr + 16'($urandom_range(0, 2047)) - 16'd1024);
			else
				queue_sample(16'($urandom()));
		end
	endtask

	initial begin
		tx_gap_ok = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		for (int i = 0; i < TABLE_SIZE; i++)
			exp_lut[i] = lut_entry(i);
		m_count = 3'd1;
		m_norm = 1'b0;
		m_offset = '0;
		for (int p = 0; p < 4; p++)
			m_peak[p] = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_gap_ok = 1'b1;

		// reset values: one zero-width peak
		queue_sample(16'h0000);
		queue_sample(16'h8000);
		drain();

		// directed: extremes, overflow both ways, count above max, normalized
		write_reg(REG_PEAK_COUNT, 48'd7);
		write_reg(REG_NORM_MODE, 48'd0);
		write_reg(REG_OFFSET, 48'h7FFF);
		write_reg(REG_PEAK0, {16'h7FFF, 16'h0100, 16'h0000});
		write_reg(REG_PEAK1, {16'h7FFF, 16'hFFFF, 16'h7FFF});
		write_reg(REG_PEAK2, {16'h8000, 16'h0001, 16'h8000});
		write_reg(REG_PEAK3, {16'h7FFF, 16'h0000, 16'h0000});
		queue_sample(16'h0000);
		queue_sample(16'h7FFF);
		queue_sample(16'h8000);
		queue_sample(16'h0100);
		queue_sample(16'hFFFF);
		queue_sample(16'h0180);
		drain();
		write_reg(REG_NORM_MODE, 48'd1);
		write_reg(REG_OFFSET, 48'h8000);
		write_reg(REG_PEAK0, {16'h8000, 16'h0001, 16'h0000});
		write_reg(REG_PEAK1, {16'h8000, 16'h0001, 16'h0000});
		queue_sample(16'h0000);
		queue_sample(16'h0001);
		queue_sample(16'h7FFF);
		queue_sample(16'hC000);
		drain();
		write_reg(REG_PEAK_COUNT, 48'd0);
		write_reg(REG_OFFSET, 48'h1234);
		queue_sample(16'h5555);
		queue_sample(16'hAAAA);
		drain();

		// random phases, each drained after; one with a long output stall, the last unclustered
		for (int ph = 0; ph < 10; ph++) begin
			random_phase(100, ph != 9);
			if (ph == 3)
				-> stall_go;
			drain();
		end

		if (errors == 0)
			$display("gaussian_sum_evaluator_top: match");
		else
			$display("gaussian_sum_evaluator_top: mismatch");
		$finish;
	end
endmodule
